>>> design/cbpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbpf_pkg
// Shared types and constants for the cubic B-spline path follower.
// ----------------------------------------------------------------------------
package cbpf_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int PHASE_BITS_DEF  = 16;
   localparam logic [15:0] TIME_FACTOR_RESET = 16'd256;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_PUSH  = 2'd1,
      ACT_SET   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDLAST,
      ST_FILL,
      ST_SETW,
      ST_WCALC,
      ST_WRND,
      ST_RDPT,
      ST_MAC,
      ST_RESP
   } state_type;

endpackage : cbpf_pkg
`default_nettype wire

>>> design/cbpf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbpf_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module cbpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule : cbpf_ram
`default_nettype wire

>>> design/cubic_bspline_path_follower_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bspline_path_follower_core
// Uniform cubic B-spline follower over a queue of 3-D control points.
// ----------------------------------------------------------------------------
// One transaction at a time: a request is taken only once the previous
// response has been accepted. Set does four RAM writes; a tick may pop the
// oldest point and, when the pop leaves three points, does one refill copy.
// The shared control-point RAM (one port, all three coordinates in one word)
// serves one access at a time: the refill copies and the four blend reads
// each use it in turn, the weights take four steps and one rounding step,
// and one multiplier per coordinate does the blend over four steps. After
// reset a clearing pass writes zero to the first four entries before the
// first request is taken; the rest are never read before being written.
// ----------------------------------------------------------------------------
module cubic_bspline_path_follower_core
   import cbpf_pkg::*;
#(
   parameter int QUEUE_DEPTH = cbpf_pkg::QUEUE_DEPTH_DEF,
   parameter int COORD_WIDTH = cbpf_pkg::COORD_WIDTH_DEF,
   parameter int PHASE_BITS  = cbpf_pkg::PHASE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_dt,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic             rsp_push_dropped
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int CWD = COORD_WIDTH;
   localparam int MW = 3 * CWD;
   localparam int UP = (PHASE_BITS >= 16) ? PHASE_BITS - 16 : 0;
   localparam int DN = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
   localparam int PW = 32 + UP;
   localparam int SW = CWD + 20;  // blend sum width
   localparam logic [CW-1:0] FOUR = CW'(4);
   localparam logic [CW-1:0] DEPTHC = CW'(QUEUE_DEPTH);

   // ---------------------------------------------------------------- state
   state_type st_ff, st_in;
   logic [15:0]         tf_ff;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [2:0]          clr_ff, clr_in;   // reset clearing pass, bit 2 = done
   logic [1:0]          act_ff, act_in;
   logic [MW-1:0]       pt_ff, pt_in;     // set point
   logic [1:0]          k_ff, k_in;
   logic                drop_ff, drop_in;
   logic                rv_ff, rv_in;
   logic signed [CWD-1:0] pos_ff [3];
   logic signed [CWD-1:0] pos_in [3];
   logic [15:0]         u_ff, u_in;
   logic [47:0]         ua_ff, ua_in;     // u^2
   logic [47:0]         ub_ff, ub_in;
   logic [50:0]         n_ff [3];         // raw weight numerators w0,w1,w3
   logic [50:0]         n_in [3];
   logic [16:0]         w_ff [4];
   logic [16:0]         w_in [4];
   logic [2:0]          ws_ff, ws_in;     // weight calc step
   logic signed [SW-1:0] acc_ff [3];
   logic signed [SW-1:0] acc_in [3];

   // ------------------------------------------------------------------ RAM
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [MW-1:0] ram_wd, ram_rd;

   cbpf_ram #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   // --------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         tf_ff <= TIME_FACTOR_RESET;
      end else if (csr_wr_en) begin
         tf_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------- helpers
   logic [MW-1:0] req_pt;
   assign req_pt = {CWD'(req_point_z), CWD'(req_point_y), CWD'(req_point_x)};

   // full-width phase sum; any bit at or above one means a wrap
   logic [31:0] prod;
   logic [PW:0] sum;
   logic        wrap;
   assign prod = 32'(req_dt) * 32'(tf_ff);
   assign sum  = (PW + 1)'(((PW'(prod) << UP) >> DN))
               + (PW + 1)'(phase_ff);
   assign wrap = |sum[PW:PHASE_BITS];

   // slot of offset k from head
   function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] h,
                                              input logic [CW-1:0] k);
      logic [CW:0] t;
      begin
         t = (CW + 1)'(h) + (CW + 1)'(k);
         if (t >= (CW + 1)'(QUEUE_DEPTH)) t = t - (CW + 1)'(QUEUE_DEPTH);
         return AW'(t);
      end
   endfunction

   logic [16:0] uc;
   assign uc = 17'd65536 - 17'(u_ff);
   localparam logic [50:0] HALF = 51'd3 << 32;

   // round half up of numerator / (6*2^32); numerator <= 2^50, quotient < 2^17
   function automatic logic [16:0] rnd_f(input logic [50:0] n);
      logic [50:0] t;
      logic [17:0] q;
      begin
         t = n + HALF;
         // divide by 6*2^32: shift then divide narrow value by 3 via recip
         q = 18'((36'(t >> 33) * 36'd43691) >> 17);
         if (51'(q) * 51'd3 > (t >> 33)) q = q - 18'd1;
         return 17'(q);
      end
   endfunction

   // blend term for one coordinate: point * weight, weight in 0..65536
   logic signed [SW-1:0] term [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         term[c] = SW'($signed(ram_rd[c*CWD +: CWD]) * $signed({1'b0, w_ff[k_ff]}));
      end
   end

   // ----------------------------------------------------------- next state
   always_comb begin
      st_in    = st_ff;
      phase_in = phase_ff;
      head_in  = head_ff;
      cnt_in   = cnt_ff;
      clr_in   = clr_ff;
      act_in   = act_ff;
      pt_in    = pt_ff;
      k_in     = k_ff;
      drop_in  = drop_ff;
      rv_in    = rv_ff;
      pos_in   = pos_ff;
      u_in     = u_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      n_in     = n_ff;
      w_in     = w_ff;
      ws_in    = ws_ff;
      acc_in   = acc_ff;
      ram_we   = 1'b0;
      ram_addr = slot_f(head_ff, cnt_ff);
      ram_wd   = pt_ff;
      req_stall = 1'b1;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (!clr_ff[2]) begin
               ram_we   = 1'b1;
               ram_addr = AW'(clr_ff[1:0]);
               ram_wd   = '0;
               clr_in   = clr_ff + 3'd1;
            end else if (!rv_ff) begin
               req_stall = 1'b0;
               if (req_valid) begin
                  act_in  = req_action;
                  drop_in = 1'b0;
                  unique case (action_type'(req_action))
                     ACT_TICK: begin
                        if (wrap) begin
                           phase_in = sum[PHASE_BITS-1:0];
                           if (cnt_ff != '0) begin
                              head_in = slot_f(head_ff, CW'(1));
                              cnt_in  = cnt_ff - CW'(1);
                           end
                           st_in = ST_RDLAST;
                        end else begin
                           phase_in = sum[PHASE_BITS-1:0];
                           st_in = ST_WCALC;
                        end
                     end
                     ACT_PUSH: begin
                        if (cnt_ff < DEPTHC) begin
                           ram_we   = 1'b1;
                           ram_wd   = req_pt;
                           ram_addr = slot_f(head_ff, cnt_ff);
                           cnt_in   = cnt_ff + CW'(1);
                        end else begin
                           drop_in = 1'b1;
                        end
                        st_in = ST_RESP;
                     end
                     ACT_SET: begin
                        pt_in   = req_pt;
                        head_in = '0;
                        cnt_in  = FOUR;
                        k_in    = 2'd0;
                        st_in   = ST_SETW;
                     end
                     default: st_in = ST_RESP;
                  endcase
                  ws_in = 3'd0;
               end
            end
         end
         ST_SETW: begin
            ram_we   = 1'b1;
            ram_addr = AW'(k_ff);
            ram_wd   = pt_ff;
            k_in     = k_ff + 2'd1;
            if (k_ff == 2'd3) st_in = ST_RESP;
         end
         ST_RDLAST: begin
            // read newest point, or head when empty
            if (cnt_ff >= FOUR) begin
               st_in = ST_WCALC;
            end else begin
               ram_addr = slot_f(head_ff, (cnt_ff == '0) ? '0 : cnt_ff - CW'(1));
               st_in = ST_FILL;
            end
         end
         ST_FILL: begin
            ram_we   = 1'b1;
            ram_wd   = ram_rd;
            ram_addr = slot_f(head_ff, cnt_ff);
            cnt_in   = cnt_ff + CW'(1);
            st_in    = ST_RDLAST;
         end
         ST_WCALC: begin
            // weight numerators, stepped by ws_ff
            ws_in = ws_ff + 3'd1;
            case (ws_ff)
               3'd0: begin
                  if (PHASE_BITS >= 16) u_in = 16'(phase_ff >> UP);
                  else                  u_in = 16'(phase_ff << DN);
               end
               3'd1: begin
                  ua_in = 48'(32'(u_ff) * 32'(u_ff));           // u^2
                  ub_in = 48'(34'(uc) * 34'(uc));               // (S-u)^2
               end
               3'd2: begin
                  n_in[2] = 51'(ua_ff[31:0] * 48'(u_ff));       // u^3
                  n_in[0] = 51'(ub_ff[33:0] * 51'(uc));         // (S-u)^3
               end
               default: begin
                  // n1 = 3u^3 - 6u^2 S + 4S^3, up to 2^50 at u = 0
                  n_in[1] = 51'(3) * n_ff[2] - ((51'(ua_ff[31:0]) * 51'd6) << 16)
                          + (51'd4 << 48);
                  st_in = ST_WRND;
               end
            endcase
         end
         ST_WRND: begin
            w_in[0] = rnd_f(n_ff[0]);
            w_in[1] = rnd_f(n_ff[1]);
            w_in[3] = rnd_f(n_ff[2]);
            k_in    = 2'd0;
            st_in   = ST_RDPT;
         end
         ST_RDPT: begin
            w_in[2]  = 17'd65536 - w_ff[0] - w_ff[1] - w_ff[3];
            ram_addr = slot_f(head_ff, CW'(k_ff));
            for (int c = 0; c < 3; c++) acc_in[c] = '0;
            st_in    = ST_MAC;
         end
         ST_MAC: begin
            for (int c = 0; c < 3; c++) acc_in[c] = acc_ff[c] + term[c];
            if (k_ff == 2'd3) begin
               for (int c = 0; c < 3; c++) begin
                  pos_in[c] = CWD'((acc_ff[c] + term[c] + SW'(32768)) >>> 16);
               end
               st_in = ST_RESP;
            end else begin
               k_in     = k_ff + 2'd1;
               ram_addr = slot_f(head_ff, CW'(k_ff + 2'd1));
            end
         end
         ST_RESP: begin
            rv_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         phase_ff <= '0;
         head_ff  <= '0;
         cnt_ff   <= FOUR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
         drop_ff  <= 1'b0;
         for (int c = 0; c < 3; c++) pos_ff[c] <= '0;
      end else begin
         st_ff    <= st_in;
         phase_ff <= phase_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         drop_ff  <= drop_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      pt_ff  <= pt_in;
      k_ff   <= k_in;
      u_ff   <= u_in;
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      n_ff   <= n_in;
      w_ff   <= w_in;
      ws_ff  <= ws_in;
      acc_ff <= acc_in;
   end

   // -------------------------------------------------------------- outputs
   assign rsp_valid        = rv_ff;
   assign rsp_pos_x        = 32'(pos_ff[0]);
   assign rsp_pos_y        = 32'(pos_ff[1]);
   assign rsp_pos_z        = 32'(pos_ff[2]);
   assign rsp_push_dropped = drop_ff & (act_ff == ACT_PUSH);
endmodule : cubic_bspline_path_follower_core
`default_nettype wire

>>> test/cubic_bspline_path_follower_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bspline_path_follower_core_tb
// Drives tick, push, set and unused transactions into the path follower,
// predicts every blended position and drop flag, and compares each response.
// ----------------------------------------------------------------------------
module cubic_bspline_path_follower_core_tb;
   import cbpf_pkg::*;

   localparam int QDEPTH = 16;

   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        dt;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } path_req_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               dropped;
   } path_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_action = '0;
   logic [15:0] req_dt = '0;
   logic signed [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic rsp_push_dropped;

   cubic_bspline_path_follower_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_dt(req_dt), .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_z(req_point_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_push_dropped(rsp_push_dropped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state
   logic [15:0] mdl_tf;
   logic [16:0] mdl_phase;
   logic signed [31:0] mdl_qx [QDEPTH];
   logic signed [31:0] mdl_qy [QDEPTH];
   logic signed [31:0] mdl_qz [QDEPTH];
   int unsigned mdl_head, mdl_count;
   logic signed [31:0] mdl_pos [3];

   path_req_type pending_reqs[$];
   path_rsp_type expected_positions[$];
   int errors = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_cycles = 0;
   int n_sent = 0, n_checked = 0, n_ticks = 0, n_drops = 0;

   function automatic int unsigned qslot(int unsigned k);
      return (mdl_head + k) % QDEPTH;
   endfunction

   function automatic logic signed [31:0] blend4(input logic signed [31:0] q [QDEPTH],
                                                 input longint w [4]);
      longint hisum, losum, c, lo;
      hisum = 0;
      losum = 0;
      for (int k = 0; k < 4; k++) begin
         c = q[qslot(k)];
         lo = c & 64'hFFFF;
         hisum += ((c - lo) / 65536) * w[k];
         losum += lo * w[k];
      end
      return 32'(hisum + ((losum + 32768) >>> 16));
   endfunction

   task automatic model_reset();
      mdl_tf = TIME_FACTOR_RESET;
      mdl_phase = '0;
      for (int i = 0; i < QDEPTH; i++) begin
         mdl_qx[i] = '0; mdl_qy[i] = '0; mdl_qz[i] = '0;
      end
      mdl_head = 0;
      mdl_count = 4;
      for (int j = 0; j < 3; j++) mdl_pos[j] = '0;
   endtask

   // Advance the spline model by one transaction and return the response.
   function automatic path_rsp_type follow_path(path_req_type r);
      path_rsp_type o;
      longint u, s, den, n0, n1, n3;
      longint w [4];
      logic [31:0] prod;
      logic [32:0] sum;
      int unsigned last, dst;
      o.dropped = 1'b0;
      s = 65536;
      den = 64'sd6 <<< 32;
      case (action_type'(r.action))
         ACT_TICK: begin
            n_ticks++;
            prod = r.dt * mdl_tf;
            sum = mdl_phase + prod;
            if (sum >= 33'h10000) begin
               mdl_phase = {1'b0, sum[15:0]};
               if (mdl_count > 0) begin
                  mdl_head = (mdl_head + 1) % QDEPTH;
                  mdl_count--;
               end
               while (mdl_count < 4) begin
                  last = qslot(mdl_count == 0 ? 0 : mdl_count - 1);
                  dst = qslot(mdl_count);
                  mdl_qx[dst] = mdl_qx[last];
                  mdl_qy[dst] = mdl_qy[last];
                  mdl_qz[dst] = mdl_qz[last];
                  mdl_count++;
               end
            end else begin
               mdl_phase = sum[16:0];
            end
            u = mdl_phase[15:0];
            n0 = (s - u) * (s - u) * (s - u);
            n3 = u * u * u;
            n1 = 3 * n3 - 6 * u * u * s + 4 * s * s * s;
            w[0] = (n0 + den / 2) / den;
            w[1] = (n1 + den / 2) / den;
            w[3] = (n3 + den / 2) / den;
            w[2] = 65536 - w[0] - w[1] - w[3];
            mdl_pos[0] = blend4(mdl_qx, w);
            mdl_pos[1] = blend4(mdl_qy, w);
            mdl_pos[2] = blend4(mdl_qz, w);
         end
         ACT_PUSH: begin
            if (mdl_count < QDEPTH) begin
               dst = qslot(mdl_count);
               mdl_qx[dst] = r.px; mdl_qy[dst] = r.py; mdl_qz[dst] = r.pz;
               mdl_count++;
            end else begin
               o.dropped = 1'b1;
            end
         end
         ACT_SET: begin
            mdl_head = 0;
            mdl_count = 4;
            for (int j = 0; j < 4; j++) begin
               mdl_qx[j] = r.px; mdl_qy[j] = r.py; mdl_qz[j] = r.pz;
            end
         end
         default: ;
      endcase
      o.x = mdl_pos[0];
      o.y = mdl_pos[1];
      o.z = mdl_pos[2];
      return o;
   endfunction

   // Input accept: predict the transaction taken at this edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_positions = {expected_positions, follow_path(pending_reqs.pop_front())};
         n_sent++;
         req_valid <= 1'b0;
      end
   end

   // Driver: offers the head of the pending queue, holds it until taken
   always @(negedge clock) begin
      if (!reset && !req_valid) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_action <= pending_reqs[0].action;
            req_dt <= pending_reqs[0].dt;
            req_point_x <= pending_reqs[0].px;
            req_point_y <= pending_reqs[0].py;
            req_point_z <= pending_reqs[0].pz;
         end
      end
   end

   // Receiver stall, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor
   always @(posedge clock) begin
      path_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_positions.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
         end else begin
            e = expected_positions.pop_front();
            n_checked++;
            if (rsp_push_dropped) n_drops++;
            if (rsp_pos_x !== e.x) begin
               $error("pos_x expected %0d actual %0d", e.x, rsp_pos_x); errors++;
            end
            if (rsp_pos_y !== e.y) begin
               $error("pos_y expected %0d actual %0d", e.y, rsp_pos_y); errors++;
            end
            if (rsp_pos_z !== e.z) begin
               $error("pos_z expected %0d actual %0d", e.z, rsp_pos_z); errors++;
            end
            if (rsp_push_dropped !== e.dropped) begin
               $error("push_dropped expected %0d actual %0d", e.dropped,
                      rsp_push_dropped);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'($urandom_range(65535) << 12) - 32'sh08000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic path_req_type make_req(action_type a, logic [15:0] dt);
      path_req_type r;
      r.action = a;
      r.dt = dt;
      r.px = rand_coord();
      r.py = rand_coord();
      r.pz = rand_coord();
      return r;
   endfunction

   task automatic add_req(path_req_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic queue_random(int n);
      int roll;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 45)
            add_req(make_req(ACT_TICK,
               ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400))));
         else if (roll < 85)
            add_req(make_req(ACT_PUSH, 16'($urandom)));
         else if (roll < 95)
            add_req(make_req(ACT_SET, 16'($urandom)));
         else
            add_req(make_req(ACT_NONE, 16'($urandom)));
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_positions.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_time_factor(logic [15:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mdl_tf = v;
   endtask

   initial begin
      model_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (8) @(posedge clock);

      // Directed: default rate, extremes, fill past full, unused action
      add_req(make_req(ACT_TICK, 16'h0000));
      add_req(make_req(ACT_SET, 16'hFFFF));
      add_req(make_req(ACT_TICK, 16'h0080));
      for (int i = 0; i < 13; i++)
         add_req(make_req(ACT_PUSH, 16'h0000));
      add_req(make_req(ACT_NONE, 16'hFFFF));
      add_req(make_req(ACT_TICK, 16'h00FF));
      add_req(make_req(ACT_TICK, 16'h0100));
      drain();
      write_time_factor(16'hFFFF);
      add_req(make_req(ACT_TICK, 16'hFFFF));
      add_req(make_req(ACT_TICK, 16'h0001));
      drain();
      write_time_factor(16'h0000);
      add_req(make_req(ACT_TICK, 16'hFFFF));
      drain();

      // Random phases with different rates and idling
      write_time_factor(16'h0100);
      send_idle_pct = 22; recv_idle_pct = 51;
      queue_random(170);
      drain();
      write_time_factor(16'($urandom));
      send_idle_pct = 51; recv_idle_pct = 22;
      queue_random(170);
      hold_cycles = 300;
      drain();
      write_time_factor(16'($urandom_range(2048)));
      send_idle_pct = 0; recv_idle_pct = 0;
      queue_random(170);
      drain();

      $display("Sent %0d transactions (%0d ticks), checked %0d responses (%0d dropped pushes),",
               n_sent, n_ticks, n_checked, n_drops);
      $display("across extreme and random time factors, a long output hold-off and three idling mixes.");
      if (errors == 0 && expected_positions.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
